FILE: rtl/core/rfr_pkg.sv
package rfr_pkg;

   localparam int NUM_ROBOTS_DEF = 4;
   localparam int MAX_ROBOTS     = 32;
   localparam int TYPE_COUNT     = 5;
   localparam int WIN_LEN        = 8;
   localparam int SUM_LEN        = 7;
   localparam int DIGIT_BITS     = 7;

   localparam int BYTE_W   = 8;
   localparam int ROBOT_W  = 5;
   localparam int DTYPE_W  = 3;
   localparam int VALUE_W  = 23;
   localparam int CSR_W    = 8;

   localparam logic [BYTE_W-1:0]  STX_BYTE       = 8'd2;
   localparam logic [BYTE_W-1:0]  ID_BASE        = 8'd31;
   localparam logic [BYTE_W-1:0]  TYPE_BASE      = 8'd88;
   localparam logic [ROBOT_W-1:0] LOCAL_RESET    = 5'd0;
   localparam logic [BYTE_W-1:0]  COMMAND_RESET  = 8'd103;

   typedef enum logic {
      OP_RX_BYTE = 1'b0,
      OP_READ    = 1'b1
   } op_type;

   typedef enum logic {
      KIND_FRAME = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_LOCAL_ROBOT  = 1'b0,
      CSR_COMMAND_CODE = 1'b1
   } csr_idx_type;

   typedef struct packed {
      op_type               op;
      logic [BYTE_W-1:0]    rx_byte;
      logic [ROBOT_W-1:0]   query_robot;
      logic [DTYPE_W-1:0]   query_type;
   } req_payload_type;

   typedef struct packed {
      kind_type             kind;
      logic [ROBOT_W-1:0]   robot_index;
      logic [DTYPE_W-1:0]   data_type;
      logic [VALUE_W-1:0]   data_value;
      logic                 from_other;
   } rsp_payload_type;

   typedef struct packed {
      csr_idx_type          index;
      logic [CSR_W-1:0]     wdata;
   } csr_payload_type;

   // Decoded frame seen in the window after the newest byte is shifted in.
   typedef struct packed {
      logic                 hit;
      logic [ROBOT_W-1:0]   robot;
      logic [DTYPE_W-1:0]   dtype;
      logic [VALUE_W-1:0]   value;
   } frame_type;

endpackage

FILE: rtl/core/rfr_chan_if.sv
interface rfr_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/rfr_window.sv
module rfr_window #(
   parameter int NumRobots = rfr_pkg::NUM_ROBOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic [rfr_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [rfr_pkg::BYTE_W-1:0]  command_code,
   output rfr_pkg::frame_type          frame
);
   import rfr_pkg::*;

   localparam logic [BYTE_W:0] ID_LIMIT = (BYTE_W+1)'(int'(ID_BASE) + NumRobots);
   localparam logic [BYTE_W:0] TYPE_LIMIT = (BYTE_W+1)'(int'(TYPE_BASE) + TYPE_COUNT);
   localparam int SUM_W = BYTE_W + $clog2(SUM_LEN);

   logic [BYTE_W-1:0] win_ff [WIN_LEN];
   logic [BYTE_W-1:0] win_nxt [WIN_LEN];
   logic [SUM_W-1:0]  sum;
   logic              id_ok;
   logic              type_ok;

   always_comb begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         win_nxt[i] = win_ff[i+1];
      end
      win_nxt[WIN_LEN-1] = rx_byte;

      sum = '0;
      for (int i = 0; i < SUM_LEN; i++) begin
         sum = sum + SUM_W'(win_nxt[i]);
      end

      id_ok   = (win_nxt[1] >= ID_BASE) && ({1'b0, win_nxt[1]} < ID_LIMIT);
      type_ok = (win_nxt[3] >= TYPE_BASE) && ({1'b0, win_nxt[3]} < TYPE_LIMIT);

      frame.hit   = (win_nxt[0] == STX_BYTE) && id_ok && (win_nxt[2] == command_code)
                    && type_ok && (sum[BYTE_W-1:0] == win_nxt[WIN_LEN-1]);
      frame.robot = ROBOT_W'(win_nxt[1] - ID_BASE);
      frame.dtype = DTYPE_W'(win_nxt[3] - TYPE_BASE);
      frame.value = (VALUE_W'(win_nxt[4]) << (2 * DIGIT_BITS))
                    + (VALUE_W'(win_nxt[5]) << DIGIT_BITS)
                    + VALUE_W'(win_nxt[6]);
   end

   // An accepted frame empties the window so that frames never overlap.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= frame.hit ? '0 : win_nxt[i];
         end
      end
   end

endmodule

FILE: rtl/core/rfr_table.sv
module rfr_table #(
   parameter int NumRobots = rfr_pkg::NUM_ROBOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [rfr_pkg::ROBOT_W-1:0]  wr_robot,
   input  logic [rfr_pkg::DTYPE_W-1:0]  wr_type,
   input  logic [rfr_pkg::VALUE_W-1:0]  wr_value,
   input  logic                         rd_en,
   input  logic [rfr_pkg::ROBOT_W-1:0]  rd_robot,
   input  logic [rfr_pkg::DTYPE_W-1:0]  rd_type,
   output logic [rfr_pkg::VALUE_W-1:0]  rd_value
);
   import rfr_pkg::*;

   localparam int DEPTH  = NumRobots * TYPE_COUNT;
   localparam int AW     = $clog2(DEPTH);
   localparam int WIDE_W = ROBOT_W + DTYPE_W;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_ok_ff;
   logic [WIDE_W-1:0]  wr_wide;
   logic [WIDE_W-1:0]  rd_wide;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic               rd_in_range;

   // Entry address is robot * 5 + type, built from a shift and two adds.
   always_comb begin
      wr_wide = (WIDE_W'(wr_robot) << 2) + WIDE_W'(wr_robot) + WIDE_W'(wr_type);
      rd_wide = (WIDE_W'(rd_robot) << 2) + WIDE_W'(rd_robot) + WIDE_W'(rd_type);
      wr_addr = wr_wide[AW-1:0];
      rd_addr = rd_wide[AW-1:0];
      rd_in_range = (32'(rd_robot) < NumRobots) && (32'(rd_type) < TYPE_COUNT);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_ok_ff   <= rd_in_range && valid_ff[rd_addr];
      end
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_value = rd_ok_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/rfr_out.sv
module rfr_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rfr_pkg::rsp_payload_type     pend_in,
   input  logic [rfr_pkg::VALUE_W-1:0]  rd_value,
   output logic                         can_accept,
   rfr_chan_if.source                   rsp_chan
);
   import rfr_pkg::*;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   rsp_payload_type s1_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_ff;
   rsp_payload_type out_in;
   logic            move;

   // The first stage waits for the table read; the second is the output register.
   always_comb begin
      move         = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
      can_accept   = !s1_valid_ff || move;
      s1_valid_in  = push ? 1'b1 : (move ? 1'b0 : s1_valid_ff);
      out_valid_in = move ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_in       = s1_ff;
      if (s1_ff.kind == KIND_READ) begin
         out_in.data_value = rd_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s1_ff <= pend_in;
      end
      if (move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

FILE: rtl/core/robot_frame_receiver.sv
// Channel   Dir  Payload                                       Accepted when
// req_chan  in   op, rx_byte, query_robot, query_type          valid && ready
// rsp_chan  out  kind, robot_index, data_type, data_value,     valid && ready
//                from_other
// csr_chan  in   index, wdata                                  valid && ready (always ready)
//
// One word is accepted every cycle while req_chan.ready is high; a frame report
// or read reply passes the registered table read and then the output register.
// Reset clears the window, the control registers and the per-entry valid flags
// directly; there is no clearing pass. Two results can wait inside the block, and
// req_chan.ready drops only while both are held by a stalled rsp_chan.
module robot_frame_receiver #(
   parameter int NumRobots = rfr_pkg::NUM_ROBOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rfr_chan_if.sink   req_chan,
   rfr_chan_if.source rsp_chan,
   rfr_chan_if.sink   csr_chan
);
   import rfr_pkg::*;

   logic [ROBOT_W-1:0]  local_robot_ff;
   logic [BYTE_W-1:0]   command_code_ff;
   req_payload_type     req;
   csr_payload_type     csr;
   logic                req_fire;
   logic                rx_shift;
   logic                rd_en;
   logic                wr_en;
   logic                push;
   logic                can_accept;
   frame_type           frame;
   rsp_payload_type     pend;
   logic [VALUE_W-1:0]  rd_value;

   assign req = req_chan.payload;
   assign csr = csr_chan.payload;

   assign req_chan.ready = can_accept;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      req_fire = req_chan.valid && req_chan.ready;
      rx_shift = req_fire && (req.op == OP_RX_BYTE);
      rd_en    = req_fire && (req.op == OP_READ);
      wr_en    = rx_shift && frame.hit;
      push     = rd_en || wr_en;

      if (rd_en) begin
         pend.kind        = KIND_READ;
         pend.robot_index = req.query_robot;
         pend.data_type   = req.query_type;
         pend.data_value  = '0;
         pend.from_other  = 1'b0;
      end else begin
         pend.kind        = KIND_FRAME;
         pend.robot_index = frame.robot;
         pend.data_type   = frame.dtype;
         pend.data_value  = frame.value;
         pend.from_other  = (frame.robot != local_robot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_robot_ff  <= LOCAL_RESET;
         command_code_ff <= COMMAND_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr.index)
            CSR_LOCAL_ROBOT:  local_robot_ff  <= csr.wdata[ROBOT_W-1:0];
            CSR_COMMAND_CODE: command_code_ff <= csr.wdata;
         endcase
      end
   end

   rfr_window #(.NumRobots(NumRobots)) u_window (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (rx_shift),
      .rx_byte      (req.rx_byte),
      .command_code (command_code_ff),
      .frame        (frame)
   );

   rfr_table #(.NumRobots(NumRobots)) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_robot (frame.robot),
      .wr_type  (frame.dtype),
      .wr_value (frame.value),
      .rd_en    (rd_en),
      .rd_robot (req.query_robot),
      .rd_type  (req.query_type),
      .rd_value (rd_value)
   );

   rfr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pend_in    (pend),
      .rd_value   (rd_value),
      .can_accept (can_accept),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: rtl/core/rfr_checker.sv
module rfr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input rfr_pkg::op_type          req_op,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rfr_pkg::rsp_payload_type rsp_payload
);
   import rfr_pkg::*;

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   // Input backpressure only happens when a result is waiting at the output.
   a_full_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result offered");

   // A read taken while the output is empty is answered through the table read stage and the output register.
   a_read_reply: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_READ) && !rsp_valid |=> ##1 rsp_valid)
      else $error("read reply missing");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind robot_frame_receiver rfr_checker u_rfr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_op      (req_chan.payload.op),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
